@@ hw/rtl/tlb_with_two_level_page_walk_macros.svh @@
// Assertion macros shared by the TLB page-walk RTL.
`ifndef TLB_WITH_TWO_LEVEL_PAGE_WALK_MACROS_SVH
`define TLB_WITH_TWO_LEVEL_PAGE_WALK_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TLBW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlbw: same-cycle check failed");
// Next-cycle implication.
`define TLBW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlbw: next-cycle check failed");
`else
`define TLBW_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLBW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/tlbw_pkg.sv @@
// Shared constants, codes and control/status types of the TLB page-walk block.
package tlbw_pkg;

  localparam int TLB_ENTRIES = 64;
  localparam int IDX_W       = $clog2(TLB_ENTRIES);
  localparam int ADDR_W      = 32;
  localparam int OFF_W       = 12;
  localparam int VPN_W       = ADDR_W - OFF_W;
  localparam int FRAME_W     = 20;
  localparam int DIR_IDX_W   = 10;
  localparam int LFSR_W      = 8;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 8'h01;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGING   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE = 1'b1;

  // Request modes and result kinds
  localparam logic MODE_TRANSLATE = 1'b0;
  localparam logic MODE_RESPONSE  = 1'b1;
  localparam logic KIND_PHYS      = 1'b0;
  localparam logic KIND_READ      = 1'b1;

  typedef enum logic [2:0] {
    RES_PASS,     // linear address unchanged
    RES_PENDING,  // pending linear address (entry not present)
    RES_DIR_REQ,  // read request for directory entry
    RES_TBL_REQ,  // read request for table entry
    RES_FILLED,   // translation from completed walk
    RES_HIT       // translation from TLB frame RAM
  } res_sel_t;

  typedef struct packed {
    logic     cap_in;
    logic     pend_load;
    logic     ram_rd;
    logic     fill;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } tlbw_cmd_t;

  typedef struct packed {
    logic mode;
    logic paging;
    logic hit;
    logic present;
    logic out_free;
  } tlbw_sts_t;

endpackage

@@ hw/rtl/tlbw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tlbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tlbw_ctrl.sv @@
// Controller: request sequencing and page-walk phase tracking.
`include "tlb_with_two_level_page_walk_macros.svh"

module tlbw_ctrl import tlbw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      request_valid,
  output logic      request_ready,
  input  tlbw_sts_t sts,
  output tlbw_cmd_t cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_HITRD, ST_SEND} state_t;
  typedef enum logic [1:0] {WALK_IDLE, WALK_DIR, WALK_TABLE} walk_t;

  state_t state, state_next;
  walk_t  walk_phase, walk_phase_next;

  assign request_ready = (state == ST_IDLE);

  always_comb begin
    cmd.cap_in      = 1'b0;
    cmd.pend_load   = 1'b0;
    cmd.ram_rd      = 1'b0;
    cmd.fill        = 1'b0;
    cmd.res_load    = 1'b0;
    cmd.res_sel     = RES_PASS;
    cmd.out_load    = 1'b0;
    state_next      = state;
    walk_phase_next = walk_phase;
    unique case (state)
      ST_IDLE: begin
        if (request_valid) begin
          cmd.cap_in = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_SEND;
        if (sts.mode == MODE_TRANSLATE) begin
          walk_phase_next = WALK_IDLE;
          if (!sts.paging) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_PASS;
          end else if (sts.hit) begin
            cmd.ram_rd = 1'b1;
            state_next = ST_HITRD;
          end else begin
            cmd.pend_load   = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_sel     = RES_DIR_REQ;
            walk_phase_next = WALK_DIR;
          end
        end else begin
          unique case (walk_phase)
            WALK_DIR: begin
              cmd.res_load = 1'b1;
              if (sts.present) begin
                cmd.res_sel     = RES_TBL_REQ;
                walk_phase_next = WALK_TABLE;
              end else begin
                cmd.res_sel     = RES_PENDING;
                walk_phase_next = WALK_IDLE;
              end
            end
            WALK_TABLE: begin
              cmd.res_load    = 1'b1;
              walk_phase_next = WALK_IDLE;
              if (sts.present) begin
                cmd.fill    = 1'b1;
                cmd.res_sel = RES_FILLED;
              end else begin
                cmd.res_sel = RES_PENDING;
              end
            end
            default: begin
              // stray response: dropped, no result
              walk_phase_next = WALK_IDLE;
              state_next      = ST_IDLE;
            end
          endcase
        end
      end
      ST_HITRD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_HIT;
        state_next   = ST_SEND;
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      walk_phase <= WALK_IDLE;
    end else begin
      state      <= state_next;
      walk_phase <= walk_phase_next;
    end
  end

  `TLBW_ASSERT_NXT(a_hitrd_to_send, clk, rst, state == ST_HITRD, state == ST_SEND)
  `TLBW_ASSERT_IMP(a_table_after_dir, clk, rst,
                   walk_phase == WALK_TABLE && $past(walk_phase) != WALK_TABLE,
                   $past(walk_phase) == WALK_DIR)
  `TLBW_ASSERT_IMP(a_fill_on_table, clk, rst, cmd.fill,
                   walk_phase == WALK_TABLE && sts.present && sts.mode == MODE_RESPONSE)

endmodule

@@ hw/rtl/tlbw_dp.sv @@
// Datapath: config registers, TLB tags and valid bits, frame RAM, result registers.
`include "tlb_with_two_level_page_walk_macros.svh"

module tlbw_dp import tlbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 mode,
  input  logic [ADDR_W-1:0]    linear_address,
  input  logic [ADDR_W-1:0]    read_data,
  input  logic                 result_ready,
  output logic                 result_valid,
  output logic                 kind,
  output logic [ADDR_W-1:0]    address,
  output logic                 tlb_hit,
  input  tlbw_cmd_t            cmd,
  output tlbw_sts_t            sts
);

  logic                 paging_enabled;
  logic [FRAME_W-1:0]   directory_base_frame;
  logic                 in_mode;
  logic [ADDR_W-1:0]    in_lin;
  logic [ADDR_W-1:0]    in_data;
  logic [ADDR_W-1:0]    pending_linear;
  logic [TLB_ENTRIES-1:0] entry_valid;
  logic [VPN_W-1:0]     entry_tag [TLB_ENTRIES];
  logic [LFSR_W-1:0]    victim_lfsr;
  logic [LFSR_W-1:0]    lfsr_next;
  logic [LFSR_W:0]      victim_wide;
  logic [IDX_W-1:0]     victim_slot;
  logic                 match_any;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free_any;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     fill_slot;
  logic [FRAME_W-1:0]   ram_rdata;
  logic                 res_kind;
  logic [ADDR_W-1:0]    res_addr;
  logic                 res_hit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enabled       <= 1'b0;
      directory_base_frame <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PAGING) begin
        paging_enabled <= cfg_data[0];
      end else if (cfg_index == CFG_DIR_BASE) begin
        directory_base_frame <= cfg_data[FRAME_W-1:0];
      end
    end
  end

  // request capture and pending walk address
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_mode <= mode;
      in_lin  <= linear_address;
      in_data <= read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_linear <= '0;
    end else if (cmd.pend_load) begin
      pending_linear <= in_lin;
    end
  end

  // parallel tag compare, lowest index wins; lowest free slot
  always_comb begin
    match_any = 1'b0;
    hit_idx   = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_tag[i] == in_lin[ADDR_W-1:OFF_W]) begin
        match_any = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // victim LFSR, taps 8,6,5,4
  always_comb begin
    lfsr_next = {victim_lfsr[LFSR_W-2:0],
                 victim_lfsr[7] ^ victim_lfsr[5] ^ victim_lfsr[4] ^ victim_lfsr[3]};
    if (lfsr_next == '0) begin
      lfsr_next = LFSR_SEED;
    end
    victim_wide = {1'b0, lfsr_next} % (LFSR_W+1)'(TLB_ENTRIES);
    victim_slot = victim_wide[IDX_W-1:0];
  end

  assign fill_slot = free_any ? free_idx : victim_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      victim_lfsr <= LFSR_SEED;
    end else if (cmd.fill) begin
      entry_valid[fill_slot] <= 1'b1;
      if (!free_any) begin
        victim_lfsr <= lfsr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      entry_tag[fill_slot] <= pending_linear[ADDR_W-1:OFF_W];
    end
  end

  tlbw_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (TLB_ENTRIES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.fill),
    .waddr (fill_slot),
    .wdata (in_data[ADDR_W-1:OFF_W]),
    .re    (cmd.ram_rd),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_hit <= 1'b0;
      unique case (cmd.res_sel)
        RES_PASS: begin
          res_kind <= KIND_PHYS;
          res_addr <= in_lin;
        end
        RES_PENDING: begin
          res_kind <= KIND_PHYS;
          res_addr <= pending_linear;
        end
        RES_DIR_REQ: begin
          res_kind <= KIND_READ;
          res_addr <= {directory_base_frame, {OFF_W{1'b0}}}
                    + {{(ADDR_W-DIR_IDX_W-2){1'b0}},
                       in_lin[ADDR_W-1:ADDR_W-DIR_IDX_W], 2'b00};
        end
        RES_TBL_REQ: begin
          res_kind <= KIND_READ;
          res_addr <= {in_data[ADDR_W-1:OFF_W], {OFF_W{1'b0}}}
                    + {{(ADDR_W-DIR_IDX_W-2){1'b0}},
                       pending_linear[OFF_W+DIR_IDX_W-1:OFF_W], 2'b00};
        end
        RES_FILLED: begin
          res_kind <= KIND_PHYS;
          res_addr <= {in_data[ADDR_W-1:OFF_W], pending_linear[OFF_W-1:0]};
        end
        RES_HIT: begin
          res_kind <= KIND_PHYS;
          res_addr <= {ram_rdata, in_lin[OFF_W-1:0]};
          res_hit  <= 1'b1;
        end
        default: begin
          res_kind <= KIND_PHYS;
          res_addr <= in_lin;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind    <= res_kind;
      address <= res_addr;
      tlb_hit <= res_hit;
    end
  end

  assign sts.mode     = in_mode;
  assign sts.paging   = paging_enabled;
  assign sts.hit      = match_any;
  assign sts.present  = in_data[0];
  assign sts.out_free = !result_valid || result_ready;

  `TLBW_ASSERT_NXT(a_fill_sets_valid, clk, rst, cmd.fill, entry_valid[$past(fill_slot)])
  `TLBW_ASSERT_IMP(a_lfsr_nonzero, clk, rst, 1'b1, victim_lfsr != '0)
  `TLBW_ASSERT_NXT(a_free_fill_keeps_lfsr, clk, rst, cmd.fill && free_any,
                   $stable(victim_lfsr))
  `TLBW_ASSERT_IMP(a_ram_read_on_hit, clk, rst, cmd.ram_rd, match_any && paging_enabled)

endmodule

@@ hw/rtl/tlb_with_two_level_page_walk.sv @@
// Top level: fully associative TLB with a two-level page walk.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------
//  request  | request_valid / request_ready | mode, linear_address, read_data
//  result   | result_valid / result_ready   | kind, address, tlb_hit
//  config   | cfg_we (no wait)              | cfg_index, cfg_data
//
// Steps: accept, evaluate, load output; a TLB hit adds a step, the registered
//   read of the frame RAM. A new request is taken only once the last is loaded.
// The 64 tags sit in flops and are compared in parallel in the evaluate cycle.
// A result waits in the output register; the next request is accepted meanwhile,
//   and that request stalls in its send step until the output register frees.
// Reset clears all valid bits at once; there is no clearing pass.
// A response request with no walk pending is dropped in its evaluate step, no result.

module tlb_with_two_level_page_walk import tlbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 request_valid,
  output logic                 request_ready,
  input  logic                 mode,
  input  logic [ADDR_W-1:0]    linear_address,
  input  logic [ADDR_W-1:0]    read_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 kind,
  output logic [ADDR_W-1:0]    address,
  output logic                 tlb_hit
);

  tlbw_cmd_t cmd;
  tlbw_sts_t sts;

  // sequencing and walk phase
  tlbw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // tags, frame RAM, address formation, output register
  tlbw_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .linear_address (linear_address),
    .read_data      (read_data),
    .result_ready   (result_ready),
    .result_valid   (result_valid),
    .kind           (kind),
    .address        (address),
    .tlb_hit        (tlb_hit),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
